// ===== design/wqa_pkg.sv =====
package wqa_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int POS_W = 24;
	localparam int YAW_W = 15;
	localparam int TAG_W = 8;
	localparam int SQ_W  = 2 * POS_W;
	localparam int DSQ_W = 51;
	localparam int RAD_W = 20;
	localparam int RSQ_W = 2 * RAD_W;
	localparam int LIM_W = 14;
	localparam int YD_W  = 17;

	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 2;

	localparam int HALF_TURN = 11520;
	localparam int FULL_TURN = 23040;

	localparam logic [RAD_W-1:0] RADIUS_RST   = RAD_W'(205);
	localparam logic [LIM_W-1:0] YAW_LIM_RST  = LIM_W'(320);

	localparam int IN_FIELDS_W = 3 * POS_W + YAW_W + TAG_W;
	localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

	// output tdata field offsets
	localparam int O_TGT_X    = 0;
	localparam int O_TGT_YAW  = 3 * POS_W;
	localparam int O_ERR_X    = O_TGT_YAW + YAW_W;
	localparam int O_ERR_YAW  = O_ERR_X + 3 * POS_W;
	localparam int O_DSQ      = O_ERR_YAW + YAW_W;
	localparam int O_ARRIVED  = O_DSQ + DSQ_W;
	localparam int O_COUNT    = O_ARRIVED + 1;
	localparam int O_DROPPED  = O_COUNT + CNT_W;
	localparam int OUT_FIELDS_W = O_DROPPED + 1;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef enum logic {
		MODE_TICK = 1'b0,
		MODE_CMD  = 1'b1
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RADIUS    = 2'd0,
		CFG_YAW_LIMIT = 2'd1,
		CFG_YAW_CHECK = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMD,
		ST_LOAD,
		ST_SQUARE,
		ST_SUM,
		ST_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic latch;
		logic load;
		logic square;
		logic sum;
		logic exec_cmd;
		logic exec_tick;
	} wqa_cmd_t;

	typedef struct packed {
		logic out_free;
	} wqa_stat_t;

	typedef struct packed {
		logic signed [YAW_W-1:0] yaw;
		logic signed [POS_W-1:0] z;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] x;
	} wp_t;

	localparam int WP_W = $bits(wp_t);

endpackage

// ===== design/wqa_ram.sv =====
module wqa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/wqa_ctrl.sv =====
module wqa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tuser,
	output logic                s_tready,
	input  wqa_pkg::wqa_stat_t  stat,
	output wqa_pkg::wqa_cmd_t   cmd
);

	wqa_pkg::ctrl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wqa_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			wqa_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (wqa_pkg::mode_t'(s_tuser) == wqa_pkg::MODE_CMD) begin
						state_nxt = wqa_pkg::ST_CMD;
					end else begin
						state_nxt = wqa_pkg::ST_LOAD;
					end
				end
			end
			wqa_pkg::ST_CMD: begin
				if (stat.out_free) state_nxt = wqa_pkg::ST_IDLE;
			end
			wqa_pkg::ST_LOAD:   state_nxt = wqa_pkg::ST_SQUARE;
			wqa_pkg::ST_SQUARE: state_nxt = wqa_pkg::ST_SUM;
			wqa_pkg::ST_SUM:    state_nxt = wqa_pkg::ST_FINISH;
			wqa_pkg::ST_FINISH: begin
				if (stat.out_free) state_nxt = wqa_pkg::ST_IDLE;
			end
			default: state_nxt = wqa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		s_tready  = 1'b0;
		unique case (state_q)
			wqa_pkg::ST_IDLE: begin
				s_tready  = 1'b1;
				cmd.latch = s_tvalid;
			end
			wqa_pkg::ST_CMD:    cmd.exec_cmd  = stat.out_free;
			wqa_pkg::ST_LOAD:   cmd.load      = 1'b1;
			wqa_pkg::ST_SQUARE: cmd.square    = 1'b1;
			wqa_pkg::ST_SUM:    cmd.sum       = 1'b1;
			wqa_pkg::ST_FINISH: cmd.exec_tick = stat.out_free;
			default: ;
		endcase
	end

endmodule

// ===== design/wqa_dp.sv =====
module wqa_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  wqa_pkg::wqa_cmd_t                  cmd,
	output wqa_pkg::wqa_stat_t                 stat,
	input  logic [wqa_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                               cfg_we,
	input  logic [wqa_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  logic [wqa_pkg::CFG_W-1:0]          cfg_wdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [wqa_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	localparam int PW = wqa_pkg::POS_W;
	localparam int YW = wqa_pkg::YAW_W;

	function automatic logic [PW-1:0] abs_diff(input logic signed [PW-1:0] a,
	                                           input logic signed [PW-1:0] b);
		logic signed [PW:0] d;
		logic [PW:0] m;
		d = {a[PW-1], a} - {b[PW-1], b};
		m = d[PW] ? -d : d;
		return m[PW-1:0];
	endfunction

	// config
	logic [wqa_pkg::RAD_W-1:0] radius_q;
	logic [wqa_pkg::LIM_W-1:0] yaw_lim_q;
	logic                      yaw_chk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= wqa_pkg::RADIUS_RST;
			yaw_lim_q <= wqa_pkg::YAW_LIM_RST;
			yaw_chk_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (wqa_pkg::cfg_idx_t'(cfg_addr))
				wqa_pkg::CFG_RADIUS:    radius_q  <= cfg_wdata[wqa_pkg::RAD_W-1:0];
				wqa_pkg::CFG_YAW_LIMIT: yaw_lim_q <= cfg_wdata[wqa_pkg::LIM_W-1:0];
				wqa_pkg::CFG_YAW_CHECK: yaw_chk_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// input beat
	logic signed [PW-1:0]          px_q, py_q, pz_q;
	logic signed [YW-1:0]          hd_q;
	logic [wqa_pkg::TAG_W-1:0]     tag_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			px_q  <= s_tdata[PW-1:0];
			py_q  <= s_tdata[2*PW-1:PW];
			pz_q  <= s_tdata[3*PW-1:2*PW];
			hd_q  <= s_tdata[3*PW+YW-1:3*PW];
			tag_q <= s_tdata[3*PW+YW+wqa_pkg::TAG_W-1:3*PW+YW];
		end
	end

	// queue
	logic [wqa_pkg::PTR_W-1:0] head_q, tail_q, head_nxt, tail_nxt;
	logic [wqa_pkg::CNT_W-1:0] cnt_q, cnt_nxt;
	logic                      full, wr_en, dropped, arrived;
	wqa_pkg::wp_t              wr_wp, rd_wp;
	logic [wqa_pkg::WP_W-1:0]  rd_raw;

	assign full  = (cnt_q == wqa_pkg::CNT_W'(wqa_pkg::QUEUE_DEPTH));
	assign wr_en = cmd.exec_cmd && (tag_q != '0) && !full;
	assign dropped = (tag_q != '0) && full;
	assign wr_wp = '{yaw: hd_q, z: pz_q, y: py_q, x: px_q};
	assign rd_wp = wqa_pkg::wp_t'(rd_raw);

	wqa_ram #(
		.WIDTH(wqa_pkg::WP_W),
		.DEPTH(wqa_pkg::QUEUE_DEPTH)
	) u_wp_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (tail_q),
		.wdata (wr_wp),
		.raddr (head_q),
		.rdata (rd_raw)
	);

	function automatic logic [wqa_pkg::PTR_W-1:0] next_slot(
		input logic [wqa_pkg::PTR_W-1:0] p);
		if (p == wqa_pkg::PTR_W'(wqa_pkg::QUEUE_DEPTH - 1)) return '0;
		return p + 1'b1;
	endfunction

	always_comb begin
		head_nxt = head_q;
		tail_nxt = tail_q;
		cnt_nxt  = cnt_q;
		if (cmd.exec_cmd) begin
			if (tag_q == '0) begin
				head_nxt = '0;
				tail_nxt = '0;
				cnt_nxt  = '0;
			end else if (!full) begin
				tail_nxt = next_slot(tail_q);
				cnt_nxt  = cnt_q + 1'b1;
			end
		end else if (cmd.exec_tick && arrived && (cnt_q >= wqa_pkg::CNT_W'(2))) begin
			head_nxt = next_slot(head_q);
			cnt_nxt  = cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			head_q <= head_nxt;
			tail_q <= tail_nxt;
			cnt_q  <= cnt_nxt;
		end
	end

	// held target and error stage
	wqa_pkg::wp_t hold_q, tgt;
	logic [PW-1:0] ex_s1, ey_s1, ez_s1, eyaw_w;
	logic [YW-1:0] eyaw_s1;

	assign tgt    = (cnt_q != '0) ? rd_wp : hold_q;
	assign eyaw_w = abs_diff(PW'(tgt.yaw), PW'(hd_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
		end else if (cmd.load) begin
			hold_q <= tgt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ex_s1   <= abs_diff(tgt.x, px_q);
			ey_s1   <= abs_diff(tgt.y, py_q);
			ez_s1   <= abs_diff(tgt.z, pz_q);
			eyaw_s1 <= eyaw_w[YW-1:0];
		end
	end

	// squares and yaw test
	logic [wqa_pkg::SQ_W-1:0]  sqx_s2, sqy_s2, sqz_s2;
	logic [wqa_pkg::RSQ_W-1:0] rsq_s2;
	logic                      yaw_ok_s2;
	logic signed [wqa_pkg::YD_W-1:0] yd_raw, yd;

	assign yd_raw = $signed({{(wqa_pkg::YD_W-YW){1'b0}}, eyaw_s1});
	assign yd     = (yd_raw > $signed(wqa_pkg::YD_W'(wqa_pkg::HALF_TURN)))
	              ? $signed(wqa_pkg::YD_W'(wqa_pkg::FULL_TURN)) - yd_raw : yd_raw;

	always_ff @(posedge clk) begin
		if (cmd.square) begin
			sqx_s2    <= wqa_pkg::SQ_W'(ex_s1) * wqa_pkg::SQ_W'(ex_s1);
			sqy_s2    <= wqa_pkg::SQ_W'(ey_s1) * wqa_pkg::SQ_W'(ey_s1);
			sqz_s2    <= wqa_pkg::SQ_W'(ez_s1) * wqa_pkg::SQ_W'(ez_s1);
			rsq_s2    <= wqa_pkg::RSQ_W'(radius_q) * wqa_pkg::RSQ_W'(radius_q);
			yaw_ok_s2 <= yd < $signed(wqa_pkg::YD_W'(yaw_lim_q));
		end
	end

	// sum
	logic [wqa_pkg::DSQ_W-1:0] dsq_s3;

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			dsq_s3 <= wqa_pkg::DSQ_W'(sqx_s2) + wqa_pkg::DSQ_W'(sqy_s2)
			        + wqa_pkg::DSQ_W'(sqz_s2);
		end
	end

	assign arrived = (dsq_s3 < wqa_pkg::DSQ_W'(rsq_s2)) && (!yaw_chk_q || yaw_ok_s2);

	// result register
	logic out_valid_q;
	logic [wqa_pkg::OUT_TDATA_W-1:0] out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec_cmd || cmd.exec_tick) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec_tick) begin
			out_q <= wqa_pkg::OUT_TDATA_W'({1'b0, cnt_nxt, arrived, dsq_s3, eyaw_s1,
			                               ez_s1, ey_s1, ex_s1, hold_q.yaw, hold_q.z,
			                               hold_q.y, hold_q.x});
		end else if (cmd.exec_cmd) begin
			// error, distance and arrived fields are zero for a command
			out_q <= wqa_pkg::OUT_TDATA_W'({dropped, cnt_nxt,
			                               {(wqa_pkg::O_COUNT - wqa_pkg::O_ERR_X){1'b0}},
			                               hold_q.yaw, hold_q.z, hold_q.y, hold_q.x});
		end
	end

	assign stat.out_free = !out_valid_q || m_tready;
	assign m_tvalid      = out_valid_q;
	assign m_tdata       = out_q;

endmodule

// ===== design/waypoint_queue_advance.sv =====
// Channel | Direction | Beat contents
// s_*     | in        | tuser: mode; tdata: pos_x, pos_y, pos_z, heading, index_tag
// m_*     | out       | tdata: target x/y/z/yaw, err x/y/z/yaw, dist_sq, arrived,
//         |           |        goal_count, dropped
// cfg_*   | in        | write: 0 arrive_radius, 1 yaw_limit, 2 yaw_check_on
//
// A command beat runs a command step, a tick beat the steps load, square, sum, finish;
// the registered waypoint RAM read and the squaring stage set the tick length.
// One beat is in work at a time; the next is taken once the result is registered.
// A result waiting on m_tready holds the block in its final step.
// arst_n clears the queue, held target and config to their reset values.
module waypoint_queue_advance (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [23:0] pos_x, [47:24] pos_y, [71:48] pos_z, [86:72] heading, [94:87] index_tag
	input  logic [wqa_pkg::IN_TDATA_W-1:0]    s_tdata,
	// [0] mode
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [23:0] target_x, [47:24] target_y, [71:48] target_z, [86:72] target_yaw,
	// [110:87] err_x, [134:111] err_y, [158:135] err_z, [173:159] err_yaw,
	// [224:174] dist_sq, [225] arrived, [230:226] goal_count, [231] dropped
	output logic [wqa_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  logic                              cfg_we,
	input  logic [wqa_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [wqa_pkg::CFG_W-1:0]         cfg_wdata
);

	wqa_pkg::wqa_cmd_t  cmd;
	wqa_pkg::wqa_stat_t stat;

	wqa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	wqa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("beat accepted while another is in work");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[wqa_pkg::O_COUNT +: wqa_pkg::CNT_W]
		              <= wqa_pkg::CNT_W'(wqa_pkg::QUEUE_DEPTH)))
		else $error("goal count above queue depth");

	a_flag_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[wqa_pkg::O_ARRIVED] && m_tdata[wqa_pkg::O_DROPPED]))
		else $error("arrived and dropped both set");

	a_drop_no_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[wqa_pkg::O_DROPPED])
		|-> (m_tdata[wqa_pkg::O_DSQ +: wqa_pkg::DSQ_W] == '0))
		else $error("dropped command with nonzero distance");

endmodule
